>>> sv/brbs_pkg.sv
// Shared constants, codes and beat types for the byte range block segmenter.
package brbs_pkg;

  localparam int unsigned BLOCK_BYTES          = 4194304;
  localparam int unsigned MAX_BLOCKS_PER_GROUP = 64;

  localparam int SIZE_W    = 48;
  localparam int BLK_W     = 32;
  localparam int OFF_W     = 22;
  localparam int LEN_W     = 23;
  localparam int KIND_W    = 3;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = $clog2(MAX_BLOCKS_PER_GROUP + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OBJECT_SIZE = 2'd0,
    CFG_RANGE_KIND  = 2'd1,
    CFG_RANGE_FIRST = 2'd2,
    CFG_RANGE_LAST  = 2'd3
  } cfg_idx_t;

  localparam logic [KIND_W-1:0] KIND_NONE       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FIRST_LAST = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OPEN       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SUFFIX     = 3'd3;

  typedef enum logic [STAT_W-1:0] {
    ST_FULL      = 2'd0,
    ST_PARTIAL   = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_UNSAT     = 2'd3
  } stat_t;

  typedef struct packed {
    logic [BLK_W-1:0]  first_block;
    logic [BLK_W-1:0]  last_block;
    logic [OFF_W-1:0]  group_offset;
    logic [SIZE_W-1:0] group_bytes;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              seg_valid;
    logic [BLK_W-1:0]  seg_block;
    logic [OFF_W-1:0]  seg_offset;
    logic [LEN_W-1:0]  seg_length;
    logic              range_done;
    logic              last_of_run;
  } out_t;

  typedef struct packed {
    logic load_in;
    logic res_a;
    logic res_b;
    logic check;
    logic step;
    logic push_pend;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic resolved;
    logic finished;
    logic grp_skip;
    logic grp_empty;
    logic seg_hit;
    logic step_last;
    logic pend_valid;
    logic out_busy;
  } sts_t;

endpackage

>>> sv/brbs_ctrl.sv
// Sequencer for resolve, group check, per-block walk and final beat.
module brbs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  brbs_pkg::sts_t sts,
  output brbs_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RES_A = 6'b000010,
    S_RES_B = 6'b000100,
    S_CHECK = 6'b001000,
    S_STEP  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = sts.resolved ? S_CHECK : S_RES_A;
        end
      end
      S_RES_A: begin
        cmd.res_a = 1'b1;
        state_nxt = S_RES_B;
      end
      S_RES_B: begin
        cmd.res_b = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.finished || sts.grp_skip || sts.grp_empty) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (!(sts.seg_hit && sts.pend_valid && sts.out_busy)) begin
          cmd.step      = 1'b1;
          cmd.push_pend = sts.seg_hit && sts.pend_valid;
          if (sts.step_last) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!sts.out_busy) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/brbs_dp.sv
// Datapath: configuration, range state, block walk arithmetic and output beat.
module brbs_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  brbs_pkg::cmd_t                     cmd,
  output brbs_pkg::sts_t                     sts,
  input  brbs_pkg::in_t                      in_data,
  input  logic                               cfg_we,
  input  logic [brbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [brbs_pkg::SIZE_W-1:0]        cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_stall,
  output brbs_pkg::out_t                     out_data
);

  localparam logic [brbs_pkg::LEN_W-1:0] BLOCK_L = brbs_pkg::LEN_W'(brbs_pkg::BLOCK_BYTES);
  localparam logic [brbs_pkg::BLK_W-1:0] MAXB_M1 =
    brbs_pkg::BLK_W'(brbs_pkg::MAX_BLOCKS_PER_GROUP - 1);

  logic [brbs_pkg::SIZE_W-1:0] obj_size_r, obj_size_nxt;
  logic [brbs_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [brbs_pkg::SIZE_W-1:0] rfirst_r, rfirst_nxt;
  logic [brbs_pkg::SIZE_W-1:0] rlast_r, rlast_nxt;

  brbs_pkg::in_t               in_r, in_nxt;
  logic [brbs_pkg::SIZE_W-1:0] start_r, start_nxt;
  logic [brbs_pkg::SIZE_W-1:0] end_r, end_nxt;

  logic [brbs_pkg::SIZE_W-1:0] skip_r, skip_nxt;
  logic [brbs_pkg::SIZE_W-1:0] need_r, need_nxt;
  logic                        resolved_r, resolved_nxt;
  logic                        finished_r, finished_nxt;
  brbs_pkg::stat_t             status_r, status_nxt;

  logic [brbs_pkg::BLK_W-1:0]  blk_r, blk_nxt;
  logic [brbs_pkg::OFF_W-1:0]  off_r, off_nxt;
  logic [brbs_pkg::SIZE_W-1:0] rem_r, rem_nxt;
  logic [brbs_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic                        pend_valid_r, pend_valid_nxt;
  logic [brbs_pkg::BLK_W-1:0]  pblk_r, pblk_nxt;
  logic [brbs_pkg::OFF_W-1:0]  poff_r, poff_nxt;
  logic [brbs_pkg::LEN_W-1:0]  plen_r, plen_nxt;
  logic                        pdone_r, pdone_nxt;

  logic                        out_valid_r, out_valid_nxt;
  brbs_pkg::out_t              out_r, out_nxt;

  logic                        grp_skip;
  logic                        grp_empty;
  logic [brbs_pkg::BLK_W-1:0]  grp_diff;
  logic [brbs_pkg::CNT_W-1:0]  grp_cnt;
  logic                        res_ok;
  logic [brbs_pkg::LEN_W-1:0]  room;
  logic [brbs_pkg::LEN_W-1:0]  cur;
  logic [brbs_pkg::LEN_W-1:0]  raw;
  logic [brbs_pkg::LEN_W-1:0]  len;
  logic                        hit;
  logic                        fin;
  logic                        step_last;
  logic [brbs_pkg::OFF_W-1:0]  seg_off;

  assign grp_skip  = (skip_r >= in_r.group_bytes);
  assign grp_empty = (in_r.last_block < in_r.first_block);
  assign grp_diff  = in_r.last_block - in_r.first_block;
  assign grp_cnt   = (grp_diff >= MAXB_M1) ? brbs_pkg::CNT_W'(brbs_pkg::MAX_BLOCKS_PER_GROUP)
                                           : grp_diff[brbs_pkg::CNT_W-1:0] + brbs_pkg::CNT_W'(1);

  assign res_ok = (kind_r == brbs_pkg::KIND_SUFFIX) ? (rfirst_r != '0) : (start_r <= end_r);

  assign room      = ({1'b0, off_r} < BLOCK_L) ? BLOCK_L - {1'b0, off_r} : '0;
  assign cur       = (rem_r < brbs_pkg::SIZE_W'(room)) ? rem_r[brbs_pkg::LEN_W-1:0] : room;
  assign hit       = (skip_r < brbs_pkg::SIZE_W'(cur));
  assign raw       = cur - skip_r[brbs_pkg::LEN_W-1:0];
  assign len       = (need_r < brbs_pkg::SIZE_W'(raw)) ? need_r[brbs_pkg::LEN_W-1:0] : raw;
  assign fin       = hit && (need_r <= brbs_pkg::SIZE_W'(raw));
  assign step_last = (cnt_r == brbs_pkg::CNT_W'(1)) || (rem_r == brbs_pkg::SIZE_W'(cur)) || fin;
  assign seg_off   = off_r + skip_r[brbs_pkg::OFF_W-1:0];

  assign sts.resolved   = resolved_r;
  assign sts.finished   = finished_r;
  assign sts.grp_skip   = grp_skip;
  assign sts.grp_empty  = grp_empty;
  assign sts.seg_hit    = hit;
  assign sts.step_last  = step_last;
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_busy   = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    obj_size_nxt   = obj_size_r;
    kind_nxt       = kind_r;
    rfirst_nxt     = rfirst_r;
    rlast_nxt      = rlast_r;
    in_nxt         = in_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    skip_nxt       = skip_r;
    need_nxt       = need_r;
    resolved_nxt   = resolved_r;
    finished_nxt   = finished_r;
    status_nxt     = status_r;
    blk_nxt        = blk_r;
    off_nxt        = off_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    pend_valid_nxt = pend_valid_r;
    pblk_nxt       = pblk_r;
    poff_nxt       = poff_r;
    plen_nxt       = plen_r;
    pdone_nxt      = pdone_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;

    if (cmd.load_in) begin
      in_nxt = in_data;
    end

    if (cmd.res_a) begin
      end_nxt = ((kind_r == brbs_pkg::KIND_FIRST_LAST) && (rlast_r < obj_size_r))
                ? rlast_r : obj_size_r - brbs_pkg::SIZE_W'(1);
      if (kind_r == brbs_pkg::KIND_SUFFIX) begin
        start_nxt = (rfirst_r >= obj_size_r) ? '0 : obj_size_r - rfirst_r;
      end else begin
        start_nxt = rfirst_r;
      end
    end

    if (cmd.res_b) begin
      resolved_nxt = 1'b1;
      finished_nxt = 1'b0;
      skip_nxt     = '0;
      need_nxt     = '0;
      priority if (obj_size_r == '0) begin
        status_nxt   = (kind_r == brbs_pkg::KIND_NONE) ? brbs_pkg::ST_FULL : brbs_pkg::ST_UNSAT;
        finished_nxt = 1'b1;
      end else if (kind_r == brbs_pkg::KIND_NONE) begin
        status_nxt = brbs_pkg::ST_FULL;
        need_nxt   = obj_size_r;
      end else if ((kind_r == brbs_pkg::KIND_FIRST_LAST) || (kind_r == brbs_pkg::KIND_OPEN) ||
                   (kind_r == brbs_pkg::KIND_SUFFIX)) begin
        if (res_ok) begin
          status_nxt = brbs_pkg::ST_PARTIAL;
          skip_nxt   = start_r;
          need_nxt   = end_r - start_r + brbs_pkg::SIZE_W'(1);
        end else begin
          status_nxt   = brbs_pkg::ST_UNSAT;
          finished_nxt = 1'b1;
        end
      end else begin
        status_nxt   = brbs_pkg::ST_MALFORMED;
        finished_nxt = 1'b1;
      end
    end

    if (cmd.check) begin
      if (!finished_r && grp_skip) begin
        skip_nxt = skip_r - in_r.group_bytes;
      end
      blk_nxt = in_r.first_block;
      off_nxt = in_r.group_offset;
      rem_nxt = in_r.group_bytes;
      cnt_nxt = grp_cnt;
    end

    if (cmd.step) begin
      if (hit) begin
        skip_nxt       = '0;
        need_nxt       = need_r - brbs_pkg::SIZE_W'(len);
        pend_valid_nxt = 1'b1;
        pblk_nxt       = blk_r;
        poff_nxt       = seg_off;
        plen_nxt       = len;
        pdone_nxt      = fin;
        if (fin) begin
          finished_nxt = 1'b1;
        end
      end else begin
        skip_nxt = skip_r - brbs_pkg::SIZE_W'(cur);
      end
      rem_nxt = rem_r - brbs_pkg::SIZE_W'(cur);
      off_nxt = '0;
      blk_nxt = blk_r + brbs_pkg::BLK_W'(1);
      cnt_nxt = cnt_r - brbs_pkg::CNT_W'(1);
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.push_pend) begin
      out_valid_nxt       = 1'b1;
      out_nxt.status      = status_r;
      out_nxt.seg_valid   = 1'b1;
      out_nxt.seg_block   = pblk_r;
      out_nxt.seg_offset  = poff_r;
      out_nxt.seg_length  = plen_r;
      out_nxt.range_done  = pdone_r;
      out_nxt.last_of_run = 1'b0;
    end

    if (cmd.flush) begin
      out_valid_nxt       = 1'b1;
      out_nxt.status      = status_r;
      out_nxt.last_of_run = 1'b1;
      pend_valid_nxt      = 1'b0;
      if (pend_valid_r) begin
        out_nxt.seg_valid  = 1'b1;
        out_nxt.seg_block  = pblk_r;
        out_nxt.seg_offset = poff_r;
        out_nxt.seg_length = plen_r;
        out_nxt.range_done = pdone_r;
      end else begin
        out_nxt.seg_valid  = 1'b0;
        out_nxt.seg_block  = '0;
        out_nxt.seg_offset = '0;
        out_nxt.seg_length = '0;
        out_nxt.range_done = finished_r;
      end
    end

    if (cfg_we) begin
      resolved_nxt = 1'b0;
      unique case (brbs_pkg::cfg_idx_t'(cfg_index))
        brbs_pkg::CFG_OBJECT_SIZE: obj_size_nxt = cfg_wdata;
        brbs_pkg::CFG_RANGE_KIND:  kind_nxt     = cfg_wdata[brbs_pkg::KIND_W-1:0];
        brbs_pkg::CFG_RANGE_FIRST: rfirst_nxt   = cfg_wdata;
        brbs_pkg::CFG_RANGE_LAST:  rlast_nxt    = cfg_wdata;
        default: begin
          resolved_nxt = resolved_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_size_r   <= '0;
      kind_r       <= '0;
      rfirst_r     <= '0;
      rlast_r      <= '0;
      skip_r       <= '0;
      need_r       <= '0;
      resolved_r   <= 1'b0;
      finished_r   <= 1'b0;
      status_r     <= brbs_pkg::ST_FULL;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      obj_size_r   <= obj_size_nxt;
      kind_r       <= kind_nxt;
      rfirst_r     <= rfirst_nxt;
      rlast_r      <= rlast_nxt;
      skip_r       <= skip_nxt;
      need_r       <= need_nxt;
      resolved_r   <= resolved_nxt;
      finished_r   <= finished_nxt;
      status_r     <= status_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r    <= in_nxt;
    start_r <= start_nxt;
    end_r   <= end_nxt;
    blk_r   <= blk_nxt;
    off_r   <= off_nxt;
    rem_r   <= rem_nxt;
    pblk_r  <= pblk_nxt;
    poff_r  <= poff_nxt;
    plen_r  <= plen_nxt;
    pdone_r <= pdone_nxt;
    out_r   <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  a_flush_shows_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (out_valid_r && out_r.last_of_run))
    else $error("final beat of an item not presented");

  a_pend_pushed: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && hit && pend_valid_r) |-> cmd.push_pend)
    else $error("held segment overwritten by a new one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_pend || cmd.flush) |-> !(out_valid_r && out_stall))
    else $error("output beat replaced while stalled");

  a_finished_no_need: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> (need_r == '0))
    else $error("range marked done with bytes still needed");
`endif

endmodule

>>> sv/byte_range_block_segmenter.sv
// Top level of the byte range block segmenter: sequencer plus datapath.
//
//   channel | direction | handshake          | beat
//   in_     | input     | in_valid/in_stall   | brbs_pkg::in_t, one block group
//   out_    | output    | out_valid/out_stall | brbs_pkg::out_t, one segment or status
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// A group is accepted in S_IDLE; the range is resolved in S_RES_A and S_RES_B on the first
// group after reset or a register write; S_CHECK checks the group; S_STEP visits each block
// (at most 64, ending early when the group's bytes or the range run out); S_FLUSH presents the final beat.
// The per-block walk through the datapath's skip/need arithmetic sets the rate.
// Output stall holds the walk when a second segment is found and holds the final beat.
// Reset is synchronous; no clearing pass follows it.
module byte_range_block_segmenter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  brbs_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output brbs_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [brbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brbs_pkg::SIZE_W-1:0]    cfg_wdata
);

  brbs_pkg::cmd_t cmd;
  brbs_pkg::sts_t sts;

  brbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  brbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
